// ===== design/polya_run_length_meter_assert.svh =====
// Assertion macros used by the run-length meter top level.
`ifndef POLYA_RUN_LENGTH_METER_ASSERT_SVH
`define POLYA_RUN_LENGTH_METER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define PLRM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PLRM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/plrm_pkg.sv =====
// Shared constants and types of the poly(A) run-length meter.
package plrm_pkg;

   localparam int CYCLE_DEPTH_DEF = 1024;
   localparam int SCORE_MAX       = 255;

   localparam int OPC_W    = 1;
   localparam int TIDX_W   = 10;
   localparam int CUT_W    = 8;
   localparam int SCORE_W  = 8;
   localparam int CNT_W    = 11;
   localparam int WEIGHT_W = 12;
   localparam int TAIL_W   = 12;
   localparam int SUM_W    = 12;
   localparam int BEST_W   = 11;
   localparam int FRAC_W   = 8;

   localparam int ROUND_HALF = 1 << (FRAC_W - 1);
   localparam int TAIL_CAP   = (1 << TAIL_W) - 1;

   localparam logic signed [SUM_W-1:0] SUM_HI = 12'sd2047;
   localparam logic signed [SUM_W-1:0] SUM_LO = -12'sd2047;

   localparam logic [OPC_W-1:0] OP_LOAD   = 1'b0;
   localparam logic [OPC_W-1:0] OP_SAMPLE = 1'b1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWNHILL_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MINIMUM_LENGTH  = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Classified sample, as it travels from the front to the back.
   typedef struct packed {
      logic first;
      logic last;
      logic nondark;
      logic down;
      logic hit;
      logic up;
   } plrm_flags_type;

endpackage

// ===== design/plrm_channels.sv =====
// Request and response channel interfaces of the run-length meter.
interface plrm_req_if import plrm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPC_W-1:0]    opcode;
   logic [TIDX_W-1:0]   table_index;
   logic [CUT_W-1:0]    cutoff_value;
   logic [SCORE_W-1:0]  score;
   logic                downhill;
   logic [TIDX_W-1:0]   start_cycle;
   logic                first_of_read;
   logic                last_of_read;

   modport source (output valid, opcode, table_index, cutoff_value, score, downhill,
                   start_cycle, first_of_read, last_of_read, input ready);
   modport sink   (input valid, opcode, table_index, cutoff_value, score, downhill,
                   start_cycle, first_of_read, last_of_read, output ready);
endinterface

interface plrm_rsp_if import plrm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TAIL_W-1:0]   tail_length;
   logic                run_found;
   logic                meets_minimum;

   modport source (output valid, tail_length, run_found, meets_minimum, input ready);
   modport sink   (input valid, tail_length, run_found, meets_minimum, output ready);
endinterface

// ===== design/polya_run_length_meter.sv =====
// Top level of the poly(A) run-length meter.
//
//   channel   direction  carries
//   req_chan  in         table load (opcode 0) or one read sample (opcode 1)
//   rsp_chan  out        tail_length, run_found, meets_minimum per closing sample
//   csr_*     in         cutoff_count, downhill_weight, minimum_length writes
//
// Cycles: one transaction per clock while req_chan.ready is high; rsp_chan.valid rises once the
// closing sample has passed table lookup, queue, back, then the four-stage length pipe.
// Reset: clears control and read state; the cutoff table is not cleared and must be
// loaded before samples use it.
// Stalls: a four-entry queue parts the front from the back; req_chan.ready drops only
// when the queue and the lookup stage together hold four samples, which happens under
// rsp_chan backpressure.
module polya_run_length_meter import plrm_pkg::*; #(
   parameter int CYCLE_DEPTH = CYCLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   plrm_req_if.sink              req_chan,
   plrm_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "polya_run_length_meter_assert.svh"

   localparam int POS_W = $clog2(2 * CYCLE_DEPTH);
   localparam int QW    = $bits(plrm_flags_type) + POS_W;

   // Configuration registers.
   logic [CNT_W-1:0]    cutoff_count_ff;
   logic [WEIGHT_W-1:0] downhill_weight_ff;
   logic [TAIL_W-1:0]   minimum_length_ff;

   // Front to queue.
   logic                q_push;
   plrm_flags_type      f_flags;
   logic [POS_W-1:0]    f_rpos;

   // Queue to back.
   logic                q_pop, q_valid;
   logic [QW-1:0]       q_dout;
   logic [QCNT_W-1:0]   q_count;
   logic                q_full;
   plrm_flags_type      b_flags;
   logic [POS_W-1:0]    b_rpos;

   // Back to length pipe.
   logic                snap_valid, snap_ready;
   logic signed [POS_W:0] snap_bp, snap_ee;

   // Take configuration writes; drop writes to indexes with no register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_count_ff    <= '0;
         downhill_weight_ff <= '0;
         minimum_length_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CUTOFF_COUNT:    cutoff_count_ff    <= CNT_W'(csr_wdata);
            CSR_DOWNHILL_WEIGHT: downhill_weight_ff <= WEIGHT_W'(csr_wdata);
            CSR_MINIMUM_LENGTH:  minimum_length_ff  <= TAIL_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Front: accept, track positions, look up the cutoff, classify the sample.
   plrm_front #(
      .CYCLE_DEPTH (CYCLE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .cutoff_count (cutoff_count_ff),
      .q_count      (q_count),
      .push         (q_push),
      .flags        (f_flags),
      .rpos         (f_rpos)
   );

   // Queue: lets the back stall without blocking accepts at once.
   plrm_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   ({f_flags, f_rpos}),
      .pop   (q_pop),
      .valid (q_valid),
      .dout  (q_dout),
      .count (q_count)
   );

   assign {b_flags, b_rpos} = q_dout;
   assign q_full            = (q_count == QCNT_W'(QUEUE_DEPTH));

   // Back: running sum, maximum and downhill extension.
   plrm_back #(
      .CYCLE_DEPTH (CYCLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .flags      (b_flags),
      .rpos       (b_rpos),
      .pop        (q_pop),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_bp    (snap_bp),
      .snap_ee    (snap_ee)
   );

   // Length pipe and output register.
   plrm_result #(
      .CYCLE_DEPTH (CYCLE_DEPTH)
   ) u_result (
      .clock           (clock),
      .reset           (reset),
      .snap_valid      (snap_valid),
      .snap_ready      (snap_ready),
      .snap_bp         (snap_bp),
      .snap_ee         (snap_ee),
      .downhill_weight (downhill_weight_ff),
      .minimum_length  (minimum_length_ff),
      .rsp             (rsp_chan)
   );

   // The front's admission rule must keep the queue within its depth.
   `PLRM_ASSERT_ALWAYS(a_queue_bound, q_count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   // The back only pops entries that are there.
   `PLRM_ASSERT_IMPLY(a_pop_nonempty, q_pop, q_count != '0, "pop from empty queue")
   // A push into a full queue is only legal when the head leaves in the same cycle.
   `PLRM_ASSERT_IMPLY(a_push_full, q_push && q_full, q_pop, "push into full queue")

endmodule

// ===== design/plrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module plrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/plrm_front.sv =====
// Front end: accepts transactions, keeps positions, looks up cutoffs, classifies.
module plrm_front import plrm_pkg::*; #(
   parameter int CYCLE_DEPTH = CYCLE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   plrm_req_if.sink                        req,
   input  logic [CNT_W-1:0]                cutoff_count,
   input  logic [QCNT_W-1:0]               q_count,
   output logic                            push,
   output plrm_flags_type                  flags,
   output logic [$clog2(2*CYCLE_DEPTH)-1:0] rpos
);

   localparam int AW      = $clog2(CYCLE_DEPTH);
   localparam int POS_W   = $clog2(2 * CYCLE_DEPTH);
   localparam int POS_CAP = 2 * CYCLE_DEPTH - 1;
   localparam int PP_W    = (POS_W > TIDX_W) ? POS_W : TIDX_W;
   localparam int LIM_W   = (PP_W > CNT_W) ? PP_W : CNT_W;
   localparam int OCC_W   = QCNT_W + 1;

   logic              accept, load, sample;
   logic [POS_W-1:0]  rp_ff, rp_in, rp_use;
   logic [PP_W-1:0]   pp_ff, pp_in, pp_use;
   logic [LIM_W-1:0]  cc_ext, max_ext, limit;
   logic              in_range;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CUT_W-1:0]  wr_data;
   logic [CUT_W-1:0]  cut;

   logic              s1_v_ff, s1_first_ff, s1_last_ff, s1_nondark_ff, s1_down_ff;
   logic              s1_inr_ff;
   logic [SCORE_W-1:0] s1_score_ff;
   logic [POS_W-1:0]  s1_rpos_ff;

   // Hold off when the queue plus the lookup stage could overflow.
   assign req.ready = (OCC_W'(q_count) + OCC_W'(s1_v_ff)) < OCC_W'(QUEUE_DEPTH);

   assign accept = req.valid && req.ready;
   assign load   = accept && (req.opcode == OP_LOAD);
   assign sample = accept && (req.opcode == OP_SAMPLE);

   assign rp_use = req.first_of_read ? '0 : rp_ff;
   assign pp_use = req.first_of_read ? PP_W'(req.start_cycle) : pp_ff;
   assign rp_in  = (rp_use < POS_W'(POS_CAP)) ? rp_use + POS_W'(1) : rp_use;
   assign pp_in  = (pp_use < PP_W'(POS_CAP)) ? pp_use + PP_W'(1) : pp_use;

   assign cc_ext   = LIM_W'(cutoff_count);
   assign max_ext  = LIM_W'(CYCLE_DEPTH);
   assign limit    = (cc_ext < max_ext) ? cc_ext : max_ext;
   assign in_range = LIM_W'(pp_use) < limit;

   // Table load: drop writes beyond the table, clamp to the score range.
   assign wr_en   = load && (int'(req.table_index) < CYCLE_DEPTH);
   assign wr_addr = AW'(req.table_index);
   assign wr_data = (int'(req.cutoff_value) > SCORE_MAX) ? CUT_W'(SCORE_MAX)
                                                         : req.cutoff_value;

   plrm_ram #(
      .WIDTH (CUT_W),
      .DEPTH (CYCLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (sample),
      .rd_addr (AW'(pp_use)),
      .rd_data (cut)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff   <= '0;
         pp_ff   <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= sample;
         if (sample) begin
            rp_ff <= rp_in;
            pp_ff <= pp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sample) begin
         s1_first_ff   <= req.first_of_read;
         s1_last_ff    <= req.last_of_read;
         s1_nondark_ff <= (req.score != '0);
         s1_down_ff    <= req.downhill;
         s1_inr_ff     <= in_range;
         s1_score_ff   <= req.score;
         s1_rpos_ff    <= rp_use;
      end
   end

   assign push          = s1_v_ff;
   assign flags.first   = s1_first_ff;
   assign flags.last    = s1_last_ff;
   assign flags.nondark = s1_nondark_ff;
   assign flags.down    = s1_down_ff;
   assign flags.hit     = s1_inr_ff && (cut != '0);
   assign flags.up      = s1_score_ff >= cut;
   assign rpos          = s1_rpos_ff;

endmodule

// ===== design/plrm_queue.sv =====
// Small FIFO between the front and the back.
module plrm_queue #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           din,
   input  logic                       pop,
   output logic                       valid,
   output logic [WIDTH-1:0]           dout,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot [DEPTH];
   logic [PTR_W-1:0] head_ff, tail_ff;
   logic [CW-1:0]    count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         end
         if (pop) begin
            head_ff <= (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot[tail_ff] <= din;
      end
   end

   assign valid = (count_ff != '0);
   assign dout  = slot[head_ff];
   assign count = count_ff;

endmodule

// ===== design/plrm_back.sv =====
// Back end: running sum, best position and downhill extension of one read.
module plrm_back import plrm_pkg::*; #(
   parameter int CYCLE_DEPTH = CYCLE_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  plrm_flags_type                         flags,
   input  logic [$clog2(2*CYCLE_DEPTH)-1:0]       rpos,
   output logic                                   pop,
   output logic                                   snap_valid,
   input  logic                                   snap_ready,
   output logic signed [$clog2(2*CYCLE_DEPTH):0]  snap_bp,
   output logic signed [$clog2(2*CYCLE_DEPTH):0]  snap_ee
);

   localparam int POS_W = $clog2(2 * CYCLE_DEPTH);
   localparam logic signed [POS_W:0] NEG_ONE = {(POS_W + 1){1'b1}};

   logic signed [SUM_W-1:0] sum_ff, sum_in, b_sum;
   logic [BEST_W-1:0]       best_ff, best_in, b_best;
   logic signed [POS_W:0]   bp_ff, bp_in, b_bp;
   logic signed [POS_W:0]   ee_ff, ee_in, b_ee;
   logic                    ext_ff, ext_in, b_ext;
   logic signed [POS_W:0]   rpos_s;

   assign rpos_s = $signed({1'b0, rpos});

   always_comb begin
      b_sum  = sum_ff;
      b_best = best_ff;
      b_bp   = bp_ff;
      b_ee   = ee_ff;
      b_ext  = ext_ff;
      if (flags.first) begin
         b_sum  = '0;
         b_best = '0;
         b_bp   = NEG_ONE;
         b_ee   = NEG_ONE;
         b_ext  = 1'b0;
      end

      sum_in  = b_sum;
      best_in = b_best;
      bp_in   = b_bp;
      ee_in   = b_ee;
      ext_in  = b_ext;

      // Extend over lit samples while downhill, stop at the first without it.
      if (b_ext && flags.nondark) begin
         if (flags.down) begin
            ee_in = rpos_s;
         end else begin
            ext_in = 1'b0;
         end
      end

      if (flags.hit) begin
         if (flags.up) begin
            if (b_sum < SUM_HI) begin
               sum_in = b_sum + SUM_W'(1);
            end
         end else begin
            if (b_sum > SUM_LO) begin
               sum_in = b_sum - SUM_W'(1);
            end
         end
         if (sum_in > $signed({1'b0, b_best})) begin
            best_in = BEST_W'(sum_in);
            bp_in   = rpos_s;
            ee_in   = NEG_ONE;
            ext_in  = 1'b1;
         end
      end
   end

   // Advance every sample; a closing sample waits for room in the length pipe.
   assign pop        = q_valid && (!flags.last || snap_ready);
   assign snap_valid = q_valid && flags.last;
   assign snap_bp    = bp_in;
   assign snap_ee    = ee_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         best_ff <= '0;
         bp_ff   <= NEG_ONE;
         ee_ff   <= NEG_ONE;
         ext_ff  <= 1'b0;
      end else if (pop) begin
         sum_ff  <= sum_in;
         best_ff <= best_in;
         bp_ff   <= bp_in;
         ee_ff   <= ee_in;
         ext_ff  <= ext_in;
      end
   end

endmodule

// ===== design/plrm_result.sv =====
// Length pipeline: extension distance, weighting, rounding, saturation, output register.
module plrm_result import plrm_pkg::*; #(
   parameter int CYCLE_DEPTH = CYCLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  snap_valid,
   output logic                                  snap_ready,
   input  logic signed [$clog2(2*CYCLE_DEPTH):0] snap_bp,
   input  logic signed [$clog2(2*CYCLE_DEPTH):0] snap_ee,
   input  logic [WEIGHT_W-1:0]                   downhill_weight,
   input  logic [TAIL_W-1:0]                     minimum_length,
   plrm_rsp_if.source                            rsp
);

   localparam int POS_W  = $clog2(2 * CYCLE_DEPTH);
   localparam int PROD_W = POS_W + WEIGHT_W;
   localparam int TW     = PROD_W + 1;

   logic                  a_v_ff, b_v_ff, c_v_ff, o_v_ff;
   logic                  a_free, b_free, c_free, o_free;
   logic signed [POS_W:0] a_bp_ff, a_ee_ff;
   logic signed [POS_W:0] a_dist;
   logic [POS_W-1:0]      b_d_ff, b_bp1_ff, c_bp1_ff;
   logic                  b_ext_ff, b_found_ff, c_ext_ff, c_found_ff;
   logic [PROD_W-1:0]     c_prod_ff;
   logic [TW-1:0]         frac, tail_full;
   logic [TAIL_W-1:0]     tail_sat;
   logic [TAIL_W-1:0]     o_tail_ff;
   logic                  o_found_ff, o_meets_ff;

   assign o_free     = !o_v_ff || rsp.ready;
   assign c_free     = !c_v_ff || o_free;
   assign b_free     = !b_v_ff || c_free;
   assign a_free     = !a_v_ff || b_free;
   assign snap_ready = a_free;

   assign a_dist = a_ee_ff - a_bp_ff;

   // Round half up, add to best position plus one when extended, saturate.
   assign frac      = (TW'(c_prod_ff) + TW'(ROUND_HALF)) >> FRAC_W;
   assign tail_full = TW'(c_bp1_ff) + (c_ext_ff ? frac : '0);
   assign tail_sat  = (tail_full > TW'(TAIL_CAP)) ? TAIL_W'(TAIL_CAP) : TAIL_W'(tail_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (a_free) a_v_ff <= snap_valid;
         if (b_free) b_v_ff <= a_v_ff;
         if (c_free) c_v_ff <= b_v_ff;
         if (o_free) o_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free && snap_valid) begin
         a_bp_ff <= snap_bp;
         a_ee_ff <= snap_ee;
      end
      if (b_free && a_v_ff) begin
         b_d_ff     <= POS_W'(a_dist);
         b_bp1_ff   <= POS_W'(a_bp_ff + (POS_W + 1)'(1));
         b_ext_ff   <= !a_ee_ff[POS_W] && !a_bp_ff[POS_W];
         b_found_ff <= !a_bp_ff[POS_W];
      end
      if (c_free && b_v_ff) begin
         c_prod_ff  <= PROD_W'(b_d_ff) * PROD_W'(downhill_weight);
         c_bp1_ff   <= b_bp1_ff;
         c_ext_ff   <= b_ext_ff;
         c_found_ff <= b_found_ff;
      end
      if (o_free && c_v_ff) begin
         o_tail_ff  <= tail_sat;
         o_found_ff <= c_found_ff;
         o_meets_ff <= tail_sat >= minimum_length;
      end
   end

   assign rsp.valid         = o_v_ff;
   assign rsp.tail_length   = o_tail_ff;
   assign rsp.run_found     = o_found_ff;
   assign rsp.meets_minimum = o_meets_ff;

endmodule
